// File: design/stack_with_range_query_macros.svh
// Assertion macros shared by the stack checker.
`ifndef STACK_WITH_RANGE_QUERY_MACROS_SVH
`define STACK_WITH_RANGE_QUERY_MACROS_SVH

// Same-cycle implication, checked on every clock while out of reset.
`define SWRQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock while out of reset.
`define SWRQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/swrq_pkg.sv
// Shared types and codes for the min/max stack.
`default_nettype none

package swrq_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned FILL_W  = 7;

    typedef enum logic [1:0] {
        MODE_PUSH  = 2'd0,
        MODE_POP   = 2'd1,
        MODE_QUERY = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EMPTY     = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_POP_EMPTY = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_FETCH  = 5'b00010,
        ST_CALC_A = 5'b00100,
        ST_CALC_B = 5'b01000,
        ST_RESP   = 5'b10000
    } state_t;

endpackage

`default_nettype wire

// File: design/stack_with_range_query.sv
// Bounded LIFO stack with per-level running minimum and maximum.
// A rejected or trivial request goes straight to the result; a pop or range query passes
// through FETCH and CALC_A, a push through FETCH, CALC_A and CALC_B. The result holds
// until taken, and only then is a new request accepted. The single registered memory read
// port and the one shared 33-bit subtract/compare unit serve both min and max updates.
// Reset clears the entry count (stack empty); stored levels are not cleared.
`default_nettype none

module stack_with_range_query #(
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [1:0]                    s_mode,
    input  wire logic signed [swrq_pkg::DATA_W-1:0] s_value,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [1:0]                         m_status,
    output logic [swrq_pkg::DATA_W-1:0]        m_result_data,
    output logic [swrq_pkg::FILL_W-1:0]        m_fill_level
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    localparam int unsigned DW = swrq_pkg::DATA_W;

    // Level storage: value, running minimum, running maximum.
    logic [DW-1:0] val_mem [DEPTH];
    logic [DW-1:0] min_mem [DEPTH];
    logic [DW-1:0] max_mem [DEPTH];

    swrq_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    swrq_pkg::mode_t   mode_reg, mode_next;
    logic [DW-1:0]     value_reg, value_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic [DW-1:0]     lo_reg, lo_next;
    logic [DW-1:0]     data_reg, data_next;
    swrq_pkg::status_t status_reg, status_next;

    logic [DW-1:0]     rd_val_reg, rd_min_reg, rd_max_reg;

    // Shared unit: signed subtract, sign bit gives a < b.
    logic [DW-1:0]     unit_a, unit_b;
    logic [DW:0]       unit_diff;
    logic              unit_less;

    logic              wr_en;
    logic [DW-1:0]     hi_val;
    swrq_pkg::mode_t   in_mode;

    assign in_mode   = swrq_pkg::mode_t'(s_mode);
    assign unit_diff = {unit_a[DW-1], unit_a} - {unit_b[DW-1], unit_b};
    assign unit_less = unit_diff[DW];

    assign s_ready       = (state_reg == swrq_pkg::ST_IDLE);
    assign m_valid       = (state_reg == swrq_pkg::ST_RESP);
    assign m_status      = status_reg;
    assign m_result_data = data_reg;
    assign m_fill_level  = swrq_pkg::FILL_W'(count_reg);

    always_comb begin
        unit_a = value_reg;
        unit_b = rd_max_reg;
        if (state_reg == swrq_pkg::ST_CALC_A) begin
            if (mode_reg == swrq_pkg::MODE_QUERY) begin
                unit_a = rd_max_reg;
                unit_b = rd_min_reg;
            end else begin
                unit_a = rd_min_reg;
                unit_b = value_reg;
            end
        end
    end

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        mode_next   = mode_reg;
        value_next  = value_reg;
        addr_next   = addr_reg;
        lo_next     = lo_reg;
        data_next   = data_reg;
        status_next = status_reg;
        wr_en       = 1'b0;
        hi_val      = value_reg;

        unique case (state_reg)
            swrq_pkg::ST_IDLE: begin
                if (s_valid) begin
                    mode_next   = in_mode;
                    value_next  = $unsigned(s_value);
                    data_next   = '0;
                    status_next = swrq_pkg::STATUS_OK;
                    state_next  = swrq_pkg::ST_RESP;
                    unique case (in_mode)
                        swrq_pkg::MODE_PUSH: begin
                            if (count_reg >= DEPTH_C) begin
                                status_next = swrq_pkg::STATUS_FULL;
                            end else begin
                                addr_next  = AW'(count_reg - CW'(1));
                                state_next = swrq_pkg::ST_FETCH;
                            end
                        end
                        swrq_pkg::MODE_POP: begin
                            if (count_reg == '0) begin
                                status_next = swrq_pkg::STATUS_EMPTY;
                            end else if (count_reg == CW'(1)) begin
                                count_next  = '0;
                                status_next = swrq_pkg::STATUS_POP_EMPTY;
                            end else begin
                                addr_next  = AW'(count_reg - CW'(2));
                                state_next = swrq_pkg::ST_FETCH;
                            end
                        end
                        swrq_pkg::MODE_QUERY: begin
                            if (count_reg == '0) begin
                                status_next = swrq_pkg::STATUS_EMPTY;
                            end else begin
                                addr_next  = AW'(count_reg - CW'(1));
                                state_next = swrq_pkg::ST_FETCH;
                            end
                        end
                        swrq_pkg::MODE_NOP: begin
                        end
                    endcase
                end
            end
            swrq_pkg::ST_FETCH: begin
                state_next = swrq_pkg::ST_CALC_A;
            end
            swrq_pkg::ST_CALC_A: begin
                unique case (mode_reg)
                    swrq_pkg::MODE_POP: begin
                        data_next  = rd_val_reg;
                        count_next = count_reg - CW'(1);
                        state_next = swrq_pkg::ST_RESP;
                    end
                    swrq_pkg::MODE_QUERY: begin
                        data_next  = unit_diff[DW-1:0];
                        state_next = swrq_pkg::ST_RESP;
                    end
                    swrq_pkg::MODE_PUSH: begin
                        // First level starts its min from its own value.
                        lo_next    = (count_reg != '0 && unit_less) ? rd_min_reg : value_reg;
                        state_next = swrq_pkg::ST_CALC_B;
                    end
                    swrq_pkg::MODE_NOP: begin
                        state_next = swrq_pkg::ST_RESP;
                    end
                endcase
            end
            swrq_pkg::ST_CALC_B: begin
                hi_val     = (count_reg != '0 && unit_less) ? rd_max_reg : value_reg;
                wr_en      = 1'b1;
                count_next = count_reg + CW'(1);
                state_next = swrq_pkg::ST_RESP;
            end
            swrq_pkg::ST_RESP: begin
                if (m_ready) begin
                    state_next = swrq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = swrq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= swrq_pkg::ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg   <= mode_next;
        value_reg  <= value_next;
        addr_reg   <= addr_next;
        lo_reg     <= lo_next;
        data_reg   <= data_next;
        status_reg <= status_next;
    end

    // Single write port at the current count, single registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            val_mem[count_reg[AW-1:0]] <= value_reg;
            min_mem[count_reg[AW-1:0]] <= lo_reg;
            max_mem[count_reg[AW-1:0]] <= hi_val;
        end
        rd_val_reg <= val_mem[addr_reg];
        rd_min_reg <= min_mem[addr_reg];
        rd_max_reg <= max_mem[addr_reg];
    end

endmodule

`default_nettype wire

// File: design/swrq_checker.sv
// Port-level checker for the min/max stack, bound to the top level.
`default_nettype none
`include "stack_with_range_query_macros.svh"

module swrq_checker #(
    parameter int unsigned DEPTH = 64
) (
    input wire logic                                  aclk,
    input wire logic                                  aresetn,
    input wire logic                                  s_valid,
    input wire logic                                  s_ready,
    input wire logic                                  m_valid,
    input wire logic                                  m_ready,
    input wire logic [1:0]                            m_status,
    input wire logic [swrq_pkg::DATA_W-1:0]           m_result_data,
    input wire logic [swrq_pkg::FILL_W-1:0]           m_fill_level
);

    logic [swrq_pkg::FILL_W-1:0] depth_fill;

    assign depth_fill = swrq_pkg::FILL_W'(DEPTH);

    // One request in flight: never ready while a result is pending.
    `SWRQ_ASSERT_NOW(a_one_in_flight, 1'b1, !(s_ready && m_valid), "ready while result pending")

    // An accepted beat closes the input until its result is taken.
    `SWRQ_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "ready after accept")

    // A stalled result holds.
    `SWRQ_ASSERT_NEXT(a_result_holds, m_valid && !m_ready,
        m_valid && $stable(m_result_data) && $stable(m_status) && $stable(m_fill_level),
        "stalled result changed")

    // A dropped push reports a full stack.
    `SWRQ_ASSERT_NOW(a_full_level, m_valid && m_status == swrq_pkg::STATUS_FULL,
        m_fill_level == depth_fill && m_result_data == '0, "full status with wrong level")

    // Popping to empty leaves nothing and reports no data.
    `SWRQ_ASSERT_NOW(a_pop_empty, m_valid && m_status == swrq_pkg::STATUS_POP_EMPTY,
        m_fill_level == '0 && m_result_data == '0,
        "pop to empty with nonzero level or data")

endmodule

bind stack_with_range_query swrq_checker #(.DEPTH(DEPTH)) u_swrq_checker (.*);

`default_nettype wire

// File: tb/sv/tb_stack_with_range_query.sv
// Self-checking testbench for the min/max stack with range query.
`timescale 1ns / 1ps

module tb_stack_with_range_query;

    localparam int STACK_DEPTH = 64;

    typedef struct packed {
        swrq_pkg::status_t status;
        logic [31:0]       data;
        logic [6:0]        fill;
    } reply_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_mode = swrq_pkg::MODE_NOP;
    logic signed [31:0] s_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [31:0] m_result_data;
    logic [6:0]  m_fill_level;

    // Shadow copy of the stack, updated on every accepted request
    logic signed [31:0] shadow_val [STACK_DEPTH];
    logic signed [31:0] shadow_lo  [STACK_DEPTH];
    logic signed [31:0] shadow_hi  [STACK_DEPTH];
    int                 held = 0;

    reply_t pending_replies [$];
    reply_t want;
    int     mismatches = 0;
    int     requests_sent = 0;
    int     replies_seen = 0;
    int     status_hits [4] = '{0, 0, 0, 0};
    bit     idle_on = 1'b1;
    int     stall_left = 0;

    stack_with_range_query #(.DEPTH(STACK_DEPTH)) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_result_data(m_result_data),
        .m_fill_level (m_fill_level)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Apply one request to the shadow stack and return the reply it should produce
    function automatic reply_t stack_apply(swrq_pkg::mode_t op, logic [31:0] val);
        reply_t r;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        r = '{swrq_pkg::STATUS_OK, 32'd0, 7'd0};
        case (op)
            swrq_pkg::MODE_PUSH: begin
                if (held >= STACK_DEPTH) begin
                    r.status = swrq_pkg::STATUS_FULL;
                end else begin
                    lo = val;
                    hi = val;
                    if (held > 0) begin
                        if (shadow_lo[held-1] < lo) lo = shadow_lo[held-1];
                        if (shadow_hi[held-1] > hi) hi = shadow_hi[held-1];
                    end
                    shadow_val[held] = val;
                    shadow_lo[held]  = lo;
                    shadow_hi[held]  = hi;
                    held++;
                end
            end
            swrq_pkg::MODE_POP: begin
                if (held == 0) begin
                    r.status = swrq_pkg::STATUS_EMPTY;
                end else begin
                    held--;
                    if (held == 0) r.status = swrq_pkg::STATUS_POP_EMPTY;
                    else r.data = shadow_val[held-1];
                end
            end
            swrq_pkg::MODE_QUERY: begin
                if (held == 0) r.status = swrq_pkg::STATUS_EMPTY;
                else r.data = shadow_hi[held-1] - shadow_lo[held-1];
            end
            default: ;
        endcase
        r.fill = held[6:0];
        status_hits[r.status]++;
        return r;
    endfunction

    // Present one request, hold it until taken, then queue the reply it should produce
    task automatic send_request(input swrq_pkg::mode_t op, input logic [31:0] val);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 15);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode  <= op;
        s_value <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_replies.push_back(stack_apply(op, val));
        requests_sent++;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                   input logic [31:0] got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s mismatch: expected %h, got %h", $realtime, what, exp_v, got_v);
    endtask

    // Result side: random stall bursts on ready
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 14);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            replies_seen++;
            if (pending_replies.size() == 0) begin
                report_mismatch("unexpected beat, status", 32'hx, m_status);
            end else begin
                want = pending_replies.pop_front();
                if (m_status !== want.status) report_mismatch("status", want.status, m_status);
                if (m_result_data !== want.data)
                    report_mismatch("result_data", want.data, m_result_data);
                if (m_fill_level !== want.fill)
                    report_mismatch("fill_level", want.fill, m_fill_level);
            end
        end
    end

    task automatic test_empty_ops();
        send_request(swrq_pkg::MODE_POP, 32'h1234_5678);
        send_request(swrq_pkg::MODE_QUERY, 32'hFFFF_FFFF);
        send_request(swrq_pkg::MODE_NOP, 32'h0);
    endtask

    task automatic test_extremes();
        send_request(swrq_pkg::MODE_PUSH, 32'h8000_0000);
        send_request(swrq_pkg::MODE_QUERY, 32'h0);
        send_request(swrq_pkg::MODE_PUSH, 32'h7FFF_FFFF);
        send_request(swrq_pkg::MODE_QUERY, 32'h0);
        send_request(swrq_pkg::MODE_PUSH, 32'hFFFF_FFFF);
        send_request(swrq_pkg::MODE_PUSH, 32'h0000_0000);
        send_request(swrq_pkg::MODE_NOP, 32'h5555_AAAA);
        send_request(swrq_pkg::MODE_QUERY, 32'h0);
        send_request(swrq_pkg::MODE_POP, 32'h0);
        send_request(swrq_pkg::MODE_POP, 32'h0);
        send_request(swrq_pkg::MODE_QUERY, 32'h0);
        send_request(swrq_pkg::MODE_POP, 32'h0);
        send_request(swrq_pkg::MODE_POP, 32'h0);
        send_request(swrq_pkg::MODE_QUERY, 32'h0);
    endtask

    // Stop sending until every outstanding reply has come back
    task automatic test_drain_pause();
        send_request(swrq_pkg::MODE_PUSH, 32'hDEAD_BEEF);
        send_request(swrq_pkg::MODE_PUSH, 32'h0000_0001);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_replies.size() != 0) @(posedge aclk);
        send_request(swrq_pkg::MODE_QUERY, 32'h0);
        send_request(swrq_pkg::MODE_POP, 32'h0);
        send_request(swrq_pkg::MODE_POP, 32'h0);
    endtask

    task automatic test_fill_and_drain();
        while (held < STACK_DEPTH) send_request(swrq_pkg::MODE_PUSH, pick_value());
        send_request(swrq_pkg::MODE_PUSH, pick_value());
        send_request(swrq_pkg::MODE_PUSH, pick_value());
        send_request(swrq_pkg::MODE_QUERY, pick_value());
        while (held > 0) begin
            if ($urandom_range(0, 3) == 0) send_request(swrq_pkg::MODE_QUERY, pick_value());
            send_request(swrq_pkg::MODE_POP, pick_value());
        end
        send_request(swrq_pkg::MODE_POP, pick_value());
    endtask

    // Mixed traffic; the push weight drifts so the stack fill rises and falls
    task automatic test_random_traffic(input int count);
        int              push_w;
        int              r;
        swrq_pkg::mode_t op;
        push_w = 50;
        for (int i = 0; i < count; i++) begin
            if (i % 32 == 0) push_w = 25 * $urandom_range(1, 3);
            r = $urandom_range(0, 99);
            if (r < 3) op = swrq_pkg::MODE_NOP;
            else if (r < 3 + push_w) op = swrq_pkg::MODE_PUSH;
            else if ($urandom_range(0, 2) == 0) op = swrq_pkg::MODE_QUERY;
            else op = swrq_pkg::MODE_POP;
            send_request(op, pick_value());
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_ops();
        test_extremes();
        test_drain_pause();
        test_fill_and_drain();
        test_random_traffic(450);
        idle_on = 1'b0;
        test_fill_and_drain();
        test_random_traffic(80);

        s_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Sent %0d requests, checked %0d replies; ok %0d, empty %0d, full %0d,",
                 requests_sent, replies_seen, status_hits[swrq_pkg::STATUS_OK],
                 status_hits[swrq_pkg::STATUS_EMPTY], status_hits[swrq_pkg::STATUS_FULL]);
        $display("popped to empty %0d, mismatches %0d",
                 status_hits[swrq_pkg::STATUS_POP_EMPTY], mismatches);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d replies outstanding", pending_replies.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: stack_with_range_query.f
+incdir+design
design/swrq_pkg.sv
design/stack_with_range_query.sv
design/swrq_checker.sv
tb/sv/tb_stack_with_range_query.sv
